// ===== rtl/rm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the running median block.
package rm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MEDIAN_W = 17;
	localparam int COUNT_W  = 9;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INSERT,
		OP_PUSH,
		OP_SWAP,
		OP_CLEAR
	} cell_op_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [MEDIAN_W-1:0] median_doubled;
		logic [COUNT_W-1:0]         count_so_far;
		logic                       dropped;
	} out_item_t;

endpackage

// ===== rtl/rm_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload item per transfer.
interface rm_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rm_cell.sv =====
`timescale 1ns / 1ps
// One cell of a sorted chain: holds one sample and trades with its neighbors.
module rm_cell import rm_pkg::*; #(
	parameter int W       = 16,
	parameter bit DESCEND = 1'b0,
	parameter bit FIRST   = 1'b0,
	parameter bit LAST    = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_op_t            op,
	input  logic signed [W-1:0] v,
	input  logic signed [W-1:0] x,
	input  logic                inner_valid,
	input  logic signed [W-1:0] inner_val,
	input  logic                inner_b,
	input  logic signed [W-1:0] outer_val,
	input  logic                outer_b,
	output logic                valid,
	output logic signed [W-1:0] val,
	output logic                b
);

	logic                valid_q;
	logic signed [W-1:0] val_q;
	logic                valid_d;
	logic signed [W-1:0] val_d;
	logic                ahead;
	logic                outer_b_eff;

	// v sorts strictly ahead of the held sample in this chain's order
	assign ahead       = DESCEND ? (v > val_q) : (v < val_q);
	assign b           = !valid_q || ahead;
	assign outer_b_eff = LAST ? 1'b1 : outer_b;

	always_comb begin
		valid_d = valid_q;
		val_d   = val_q;
		unique case (op)
			OP_INSERT: begin
				valid_d = FIRST ? 1'b1 : inner_valid;
				if (b) begin
					val_d = (FIRST || !inner_b) ? v : inner_val;
				end
			end
			OP_PUSH: begin
				valid_d = FIRST ? 1'b1 : inner_valid;
				val_d   = FIRST ? x : inner_val;
			end
			OP_SWAP: begin
				// drop the head, insert v
				if (!outer_b_eff) begin
					val_d = outer_val;
				end else if (FIRST || !b) begin
					val_d = v;
				end
			end
			OP_CLEAR: valid_d = 1'b0;
			default: begin
				valid_d = valid_q;
				val_d   = val_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign valid = valid_q;
	assign val   = val_q;

endmodule

// ===== rtl/rm_chain.sv =====
`timescale 1ns / 1ps
// Sorted chain of cells; the head cell holds the sample nearest the median.
module rm_chain import rm_pkg::*; #(
	parameter int N       = 128,
	parameter int W       = 16,
	parameter bit DESCEND = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_op_t            op,
	input  logic signed [W-1:0] v,
	input  logic signed [W-1:0] x,
	output logic signed [W-1:0] head_val,
	output logic                head_b
);

	logic                valid_w [N];
	logic signed [W-1:0] val_w   [N];
	logic                b_w     [N];

	for (genvar i = 0; i < N; i++) begin : g_cell
		localparam int IN_IDX  = (i == 0) ? 0 : i - 1;
		localparam int OUT_IDX = (i == N - 1) ? i : i + 1;

		rm_cell #(
			.W       (W),
			.DESCEND (DESCEND),
			.FIRST   (i == 0),
			.LAST    (i == N - 1)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (op),
			.v           (v),
			.x           (x),
			.inner_valid (valid_w[IN_IDX]),
			.inner_val   (val_w[IN_IDX]),
			.inner_b     (b_w[IN_IDX]),
			.outer_val   (val_w[OUT_IDX]),
			.outer_b     (b_w[OUT_IDX]),
			.valid       (valid_w[i]),
			.val         (val_w[i]),
			.b           (b_w[i])
		);
	end

	assign head_val = val_w[0];
	assign head_b   = b_w[0];

endmodule

// ===== rtl/running_median_top.sv =====
`timescale 1ns / 1ps
// Running median top level: two sorted cell chains around the median.
//
// sample_ch takes one signed sample per transfer with a last_sample flag.
// median_ch gives one result per sample: twice the median of all samples kept
// since the stream began, the number kept, and a dropped flag.
// The lower half sits in a descending chain, the upper half in an ascending
// chain, so the middle values are always in the two head cells. Each sample
// is sorted into its chain by all cells in parallel.
// A result passes through the valid_s1 register and the output register
// after its sample transfer. Throughput is one sample per cycle while
// median_ch is ready; after a sample flagged last, ready is low as the chains clear.
// When the store holds CAPACITY samples, a new sample is not kept, dropped is
// set and the median repeats.
// Reset empties both chains at once. When median_ch stalls, the result is
// held and one further sample sits in the chains awaiting its turn; after
// that sample_ch deasserts ready until the output moves.
module running_median_top import rm_pkg::*; #(
	parameter int CAPACITY    = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	rm_stream_if.sink   sample_ch,
	rm_stream_if.source median_ch
);

	localparam int W     = SAMPLE_BITS;
	localparam int LN    = (CAPACITY + 1) / 2;
	localparam int UN    = CAPACITY / 2;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [W+SAMPLE_W-1:0]  raw_ext;
	logic signed [W-1:0]    v;
	logic                   accept;
	logic                   adv;
	logic [CNT_W-1:0]       nl_q, nu_q, nl_d, nu_d;
	logic [CNT_W-1:0]       total;
	logic                   full;
	logic                   go_low;
	logic                   balanced;
	cell_op_t               op_l, op_u;
	logic signed [W-1:0]    x_l, x_u;
	logic signed [W-1:0]    l_head, u_head;
	logic                   l_b, u_b;
	logic                   valid_s1, last_s1, drop_s1;
	logic                   out_valid_q;
	out_item_t              out_data_q;
	logic signed [W:0]      med_sum;
	logic [W+MEDIAN_W:0]    med_ext;
	logic [CNT_W+COUNT_W-1:0] cnt_ext;

	assign raw_ext = {{W{1'b0}}, sample_ch.data.sample};
	assign v       = raw_ext[W-1:0];

	assign adv    = !out_valid_q || median_ch.ready;
	assign sample_ch.ready = !valid_s1 || (adv && !last_s1);
	assign accept = sample_ch.valid && sample_ch.ready;

	assign total    = nl_q + nu_q;
	assign full     = (total == CNT_W'(CAPACITY));
	assign balanced = (nl_q == nu_q);
	assign go_low   = (nl_q == '0) || !l_b;

	always_comb begin
		op_l = OP_HOLD;
		op_u = OP_HOLD;
		x_l  = u_head;
		x_u  = l_head;
		nl_d = nl_q;
		nu_d = nu_q;
		if (adv && valid_s1 && last_s1) begin
			op_l = OP_CLEAR;
			op_u = OP_CLEAR;
			nl_d = '0;
			nu_d = '0;
		end else if (accept && !full) begin
			if (go_low && balanced) begin
				op_l = OP_INSERT;
				nl_d = nl_q + CNT_W'(1);
			end else if (go_low) begin
				// lower half is long: its head moves up
				op_l = OP_SWAP;
				op_u = OP_PUSH;
				nu_d = nu_q + CNT_W'(1);
			end else if (!balanced) begin
				op_u = OP_INSERT;
				nu_d = nu_q + CNT_W'(1);
			end else begin
				// the smaller of v and the upper head moves down
				x_l  = u_b ? v : u_head;
				op_l = OP_PUSH;
				op_u = u_b ? OP_HOLD : OP_SWAP;
				nl_d = nl_q + CNT_W'(1);
			end
		end
	end

	rm_chain #(.N(LN), .W(W), .DESCEND(1'b1)) u_lower (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op_l),
		.v        (v),
		.x        (x_l),
		.head_val (l_head),
		.head_b   (l_b)
	);

	rm_chain #(.N(UN), .W(W), .DESCEND(1'b0)) u_upper (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op_u),
		.v        (v),
		.x        (x_u),
		.head_val (u_head),
		.head_b   (u_b)
	);

	always_comb begin
		if (!balanced) begin
			med_sum = {l_head, 1'b0};
		end else begin
			med_sum = {l_head[W-1], l_head} + {u_head[W-1], u_head};
		end
	end

	assign med_ext = {{MEDIAN_W{med_sum[W]}}, med_sum};
	assign cnt_ext = {{COUNT_W{1'b0}}, total};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nl_q        <= '0;
			nu_q        <= '0;
			valid_s1    <= 1'b0;
			last_s1     <= 1'b0;
			drop_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			nl_q <= nl_d;
			nu_q <= nu_d;
			if (accept) begin
				valid_s1 <= 1'b1;
				last_s1  <= sample_ch.data.last_sample;
				drop_s1  <= full;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv && valid_s1) begin
				out_valid_q <= 1'b1;
			end else if (median_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_data_q.median_doubled <= med_ext[MEDIAN_W-1:0];
			out_data_q.count_so_far   <= cnt_ext[COUNT_W-1:0];
			out_data_q.dropped        <= drop_s1;
		end
	end

	assign median_ch.valid = out_valid_q;
	assign median_ch.data  = out_data_q;

	a_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(nl_q == nu_q) || (nl_q == nu_q + CNT_W'(1)))
		else $error("chain halves out of balance");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(nl_q + nu_q) <= CNT_W'(CAPACITY))
		else $error("stored count above capacity");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1) |-> !accept)
		else $error("sample taken while chains clear");

	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !full) |=> (total == $past(total) + CNT_W'(1)))
		else $error("kept sample did not raise the count");

endmodule

// ===== dv/median_checker.sv =====
`timescale 1ns / 1ps
// Checker for the running median block: tracks the sorted sample set and compares each result.
module median_checker import rm_pkg::*; #(
	parameter int CAPACITY    = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	output int        mismatches,
	output int        pending,
	output int        results_seen,
	output int        drops_seen
);

	// Samples of the current stream, ascending, widened to int.
	int          sorted_vals[CAPACITY];
	int unsigned held = 0;
	out_item_t   awaiting_medians[$];

	initial begin
		mismatches   = 0;
		pending      = 0;
		results_seen = 0;
		drops_seen   = 0;
	end

	function automatic out_item_t insert_and_median(in_item_t it);
		int        v;
		int        pos;
		int        twice_mid;
		bit        full;
		out_item_t r;
		// keep only the low SAMPLE_BITS bits, sign-extended
		v = int'($unsigned(it.sample));
		v = (v <<< (32 - SAMPLE_BITS)) >>> (32 - SAMPLE_BITS);
		full = (held >= CAPACITY);
		if (!full) begin
			pos = held;
			// equal values land after the ones already held
			while (pos > 0 && sorted_vals[pos-1] > v) begin
				sorted_vals[pos] = sorted_vals[pos-1];
				pos--;
			end
			sorted_vals[pos] = v;
			held++;
		end
		if (held[0])
			twice_mid = 2 * sorted_vals[held/2];
		else
			twice_mid = sorted_vals[held/2 - 1] + sorted_vals[held/2];
		r.median_doubled = MEDIAN_W'(twice_mid);
		r.count_so_far   = COUNT_W'(held);
		r.dropped        = full;
		if (it.last_sample)
			held = 0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			held = 0;
			awaiting_medians.delete();
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				awaiting_medians.insert(awaiting_medians.size(), insert_and_median(in_data));
			if (out_valid && out_ready) begin
				results_seen++;
				if (out_data.dropped)
					drops_seen++;
				if (awaiting_medians.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result median=%0d count=%0d dropped=%0b",
							$time, out_data.median_doubled, out_data.count_so_far,
							out_data.dropped);
				end else begin
					want = awaiting_medians.pop_front();
					if (want.median_doubled !== out_data.median_doubled ||
					    want.count_so_far !== out_data.count_so_far ||
					    want.dropped !== out_data.dropped) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: result mismatch: expected median=%0d count=%0d ",
								"dropped=%0b, got median=%0d count=%0d dropped=%0b"},
								$time, want.median_doubled, want.count_so_far,
								want.dropped, out_data.median_doubled,
								out_data.count_so_far, out_data.dropped);
					end
				end
			end
			pending <= awaiting_medians.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the running median block: stimulus, receiver stalls and verdict.
module tb import rm_pkg::*; ();

	localparam int CAPACITY    = 256;
	localparam int SAMPLE_BITS = 16;
	localparam int ITEMS       = 1300;
	localparam int HOLD_CYCLES = 80;

	logic clk;
	logic arst_n;

	rm_stream_if #(.payload_t(in_item_t))  sample_ch();
	rm_stream_if #(.payload_t(out_item_t)) median_ch();

	int mismatches;
	int pending;
	int results_seen;
	int drops_seen;

	int samples_sent = 0;
	int streams_sent = 0;
	int holds_done   = 0;
	bit tx_quiet     = 0;
	bit rx_quiet     = 0;
	bit hold_req     = 0;

	running_median_top #(
		.CAPACITY   (CAPACITY),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample_ch(sample_ch),
		.median_ch(median_ch)
	);

	median_checker #(
		.CAPACITY   (CAPACITY),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (sample_ch.valid),
		.in_ready    (sample_ch.ready),
		.in_data     (sample_ch.data),
		.out_valid   (median_ch.valid),
		.out_ready   (median_ch.ready),
		.out_data    (median_ch.data),
		.mismatches  (mismatches),
		.pending     (pending),
		.results_seen(results_seen),
		.drops_seen  (drops_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", pending);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int tx_gap();
		return tx_quiet ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh0000;
					default: return 16'shFFFF;
				endcase
			end
			// narrow range, so duplicates are common
			1, 2, 3: return SAMPLE_W'($signed($urandom_range(0, 8)) - 4);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic lst, int gap);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.data  <= '{sample: s, last_sample: lst};
		do @(posedge clk); while (!sample_ch.ready);
		samples_sent++;
		if (lst)
			streams_sent++;
	endtask

	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic send_stream(int len);
		for (int i = 0; i < len; i++)
			send_sample(pick_sample(), i == len - 1, tx_gap());
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int stall;
		median_ch.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				median_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
				holds_done++;
			end
			stall = rx_quiet ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				median_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			median_ch.ready <= 1'b1;
			do @(posedge clk); while (!median_ch.valid);
		end
	end

	initial begin
		int len;
		sample_ch.valid = 1'b0;
		sample_ch.data  = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, odd and even counts, duplicates, out-of-order inserts
		send_sample(16'sh7FFF, 1'b1, tx_gap());
		send_sample(16'sh8000, 1'b1, tx_gap());
		send_sample(16'sh8000, 1'b0, tx_gap());
		send_sample(16'sh7FFF, 1'b1, tx_gap());
		send_sample(16'sh7FFF, 1'b0, tx_gap());
		send_sample(16'sh7FFF, 1'b1, tx_gap());
		send_sample(16'sh8000, 1'b0, tx_gap());
		send_sample(16'sh8000, 1'b1, tx_gap());
		send_sample(16'sh0000, 1'b0, tx_gap());
		send_sample(16'shFFFF, 1'b0, tx_gap());
		send_sample(16'sh0001, 1'b1, tx_gap());
		repeat (4) send_sample(16'sh0005, 1'b0, tx_gap());
		send_sample(16'sh0005, 1'b1, tx_gap());
		send_sample(16'sh5555, 1'b0, tx_gap());
		send_sample(16'shAAAA, 1'b1, tx_gap());
		send_sample(16'sh0003, 1'b0, tx_gap());
		send_sample(-16'sd7, 1'b0, tx_gap());
		send_sample(16'sh0002, 1'b0, tx_gap());
		send_sample(16'sh0009, 1'b1, tx_gap());

		// hold until every result is back
		drain_results();

		// back-to-back stream past capacity while the receiver holds off;
		// the closing sample is dropped and still clears the store
		tx_quiet = 1;
		hold_req = 1;
		send_stream(CAPACITY + 14);
		tx_quiet = 0;
		drain_results();

		while (samples_sent < ITEMS) begin
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(CAPACITY - 6, CAPACITY + 44);
			else
				len = $urandom_range(1, 30);
			send_stream(len);
			if ($urandom_range(0, 7) == 0)
				drain_results();
		end
		tx_quiet = 0;
		rx_quiet = 0;
		drain_results();
		repeat (10) @(posedge clk);

		$display("Covered %0d samples in %0d streams; %0d medians checked, %0d dropped samples.",
			samples_sent, streams_sent, results_seen, drops_seen);
		$display("Receiver long hold-offs: %0d; mismatches: %0d.", holds_done, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/rm_pkg.sv
rtl/rm_stream_if.sv
rtl/rm_cell.sv
rtl/rm_chain.sv
rtl/running_median_top.sv
dv/median_checker.sv
dv/tb.sv
